// ===== sv/dws_pkg.sv =====
// Shared constants, register codes and controller/datapath bundles for the
// disparity winner select core. No dependencies.

package dws_pkg;

	// Field widths
	localparam int COST_W      = 11;
	localparam int MIN_W       = 9;
	localparam int MAX_W       = 10;
	localparam int MARGIN_W    = 9;
	localparam int MARGIN_FRAC = 8;
	localparam int OUT_W       = 14;

	// Search range and fixed point format
	localparam int MAX_RANGE = 256;
	localparam int FRAC_BITS = 4;

	// Derived widths
	localparam int POS_W  = $clog2(MAX_RANGE);
	localparam int RNG_W  = $clog2(MAX_RANGE + 1);
	localparam int DIFF_W = (RNG_W + 1 > MAX_W + 1) ? RNG_W + 1 : MAX_W + 1;
	localparam int SUM_W  = ((POS_W + 1 > MIN_W) ? POS_W + 1 : MIN_W) + 1;
	localparam int QW     = COST_W + FRAC_BITS;
	localparam int DEN_W  = COST_W + 1;
	localparam int DVS_W  = COST_W + 2;
	localparam int PROD_W = COST_W + MARGIN_W;
	localparam int LIM_W  = PROD_W - MARGIN_FRAC;
	localparam int CNT_W  = $clog2(QW + 1);
	localparam int ACC_A  = (SUM_W + FRAC_BITS > QW + 1) ? SUM_W + FRAC_BITS : QW + 1;
	localparam int ACC_W  = ((ACC_A > OUT_W) ? ACC_A : OUT_W) + 1;

	// Clamp bounds for the active range
	localparam logic signed [DIFF_W-1:0] RANGE_TOP = DIFF_W'(MAX_RANGE);
	localparam logic signed [DIFF_W-1:0] RANGE_BOT = DIFF_W'(1);

	// Stream and configuration port widths
	localparam int S_TDATA_W  = ((COST_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((OUT_W + 7) / 8) * 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = MAX_W;

	// Output saturation bounds
	localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(2 ** (OUT_W - 1)));
	localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((2 ** (OUT_W - 1)) - 1);

	// Register reset values
	localparam logic [MIN_W-1:0]    MIN_DISP_RST = MIN_W'(0);
	localparam logic [MAX_W-1:0]    MAX_DISP_RST = MAX_W'(64);
	localparam logic                UNIQ_RST     = 1'b1;
	localparam logic [MARGIN_W-1:0] MARGIN_RST   = MARGIN_W'(13);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DISP_LO           = 2'd0,
		CFG_DISP_HI           = 2'd1,
		CFG_CHECK_UNIQUE      = 2'd2,
		CFG_UNIQUENESS_MARGIN = 2'd3
	} cfg_idx_t;

	// Controller to datapath
	typedef struct packed {
		logic take;       // accepted cost word, update tracking state
		logic prod_en;    // snapshot pixel state, clear tracking
		logic check_en;   // register the verdict
		logic div_start;  // launch subpixel division
		logic load_out;   // fill output register
	} dws_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic last_cost;  // current word closes the pixel
		logic est_ok;     // uniqueness and edge tests pass
		logic div_done;   // final division step this cycle
	} dws_stat_t;

endpackage

// ===== sv/disparity_winner_select_core.sv =====
// Top level of the winner-take-all disparity selector with parabola subpixel
// refinement. Depends on dws_pkg, dws_ctrl, dws_datapath and dws_div.
//
// Usage:
//   Slave stream carries one aggregated cost word per disparity, from the
//   lowest searched disparity upward; range = upper limit - lowest disparity,
//   clamped to 1..MAX_RANGE. After the last cost of a pixel one result word
//   leaves on the master stream: m_tdata holds the signed subpixel disparity
//   (FRAC_BITS fraction bits), m_tuser flags a valid estimate; rejected pixels
//   give zero.
//   Costs are taken one per cycle while a pixel accumulates. After the last
//   cost, s_tready stays low through the PROD, CHECK and EMIT states and,
//   for a valid pixel, through the division, one quotient bit per cycle.
//   The result shows on m_tvalid in the cycle s_tready returns. The output
//   register holds the result while the receiver stalls and the next pixel
//   accumulates meanwhile; only the next hand-off waits for it to drain.
//   Reset clears all per-pixel tracking and loads the register defaults
//   (lowest disparity 0, upper limit 64, uniqueness on, margin 13/256).
//   Configuration words are always accepted; write them only while no pixel
//   is in flight.

module disparity_winner_select_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// Cost stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [dws_pkg::S_TDATA_W-1:0]  s_tdata,   // [10:0] cost, rest zero
	// Result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [dws_pkg::M_TDATA_W-1:0]  m_tdata,   // [13:0] disparity, rest zero
	output logic                           m_tuser,   // [0] valid_res
	// Register writes
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dws_pkg::CFG_DATA_W-1:0] cfg_data
);

	dws_pkg::dws_cmd_t         cmd;
	dws_pkg::dws_stat_t        stat;
	logic [dws_pkg::OUT_W-1:0] disparity;

	// Register writes never stall
	assign cfg_ready = 1'b1;

	dws_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	dws_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cost      (s_tdata[dws_pkg::COST_W-1:0]),
		.cmd       (cmd),
		.stat      (stat),
		.disparity (disparity),
		.valid_res (m_tuser)
	);

	// Zero-pad the disparity up to whole bytes
	assign m_tdata = dws_pkg::M_TDATA_W'(disparity);

endmodule

// ===== sv/dws_div.sv =====
// Restoring divider, one quotient bit per cycle, for the subpixel offset.
// Depends on dws_pkg.

module dws_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dws_pkg::QW-1:0]    dividend,
	input  logic [dws_pkg::DVS_W-1:0] divisor,
	output logic [dws_pkg::QW-1:0]    quotient,
	output logic                      done
);

	logic [dws_pkg::QW-1:0]    shift_q;
	logic [dws_pkg::DVS_W-1:0] rem_q;
	logic [dws_pkg::DVS_W-1:0] dvs_q;
	logic [dws_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic [dws_pkg::DVS_W:0]   trial;
	logic                      fits;

	always_comb begin
		trial = {rem_q, shift_q[dws_pkg::QW-1]};
		fits  = trial >= {1'b0, dvs_q};
	end

	assign done     = busy_q && (cnt_q == dws_pkg::CNT_W'(dws_pkg::QW - 1));
	assign quotient = shift_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + dws_pkg::CNT_W'(1);
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Payload: shift the dividend out at the top, quotient bits in at the bottom
	always_ff @(posedge clk) begin
		if (start) begin
			shift_q <= dividend;
			rem_q   <= '0;
			dvs_q   <= divisor;
		end else if (busy_q) begin
			shift_q <= {shift_q[dws_pkg::QW-2:0], fits};
			rem_q   <= fits ? dws_pkg::DVS_W'(trial - {1'b0, dvs_q})
			                : trial[dws_pkg::DVS_W-1:0];
		end
	end

endmodule

// ===== sv/dws_datapath.sv =====
// Datapath: configuration registers, per-pixel cost tracking, verdict,
// subpixel offset and output register. Depends on dws_pkg and dws_div.

module dws_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [dws_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dws_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic [dws_pkg::COST_W-1:0]     cost,
	input  dws_pkg::dws_cmd_t              cmd,
	output dws_pkg::dws_stat_t             stat,
	output logic [dws_pkg::OUT_W-1:0]      disparity,
	output logic                           valid_res
);

	// Configuration
	logic [dws_pkg::MIN_W-1:0]    min_disp_q;
	logic [dws_pkg::MAX_W-1:0]    max_disp_q;
	logic                         uniq_q;
	logic [dws_pkg::MARGIN_W-1:0] margin_q;

	// Pixel tracking
	logic [dws_pkg::POS_W-1:0]  position_q;
	logic [dws_pkg::COST_W-1:0] best_q;
	logic [dws_pkg::COST_W-1:0] runner_q;
	logic [dws_pkg::POS_W-1:0]  best_pos_q;
	logic [dws_pkg::COST_W-1:0] prev_q;
	logic [dws_pkg::COST_W-1:0] below_q;
	logic [dws_pkg::COST_W-1:0] above_q;
	logic                       await_q;

	// Snapshot at end of pixel
	logic [dws_pkg::PROD_W-1:0]       prod_q;
	logic [dws_pkg::COST_W-1:0]       gap_q;
	logic                             edge_q;
	logic signed [dws_pkg::SUM_W-1:0] sum_q;
	logic [dws_pkg::COST_W-1:0]       diff_q;
	logic                             neg_q;
	logic [dws_pkg::DEN_W-1:0]        den_q;
	logic                             verdict_q;

	// Output register
	logic [dws_pkg::OUT_W-1:0] disp_q;
	logic                      vres_q;

	logic signed [dws_pkg::DIFF_W-1:0] span;
	logic [dws_pkg::RNG_W-1:0]         range;
	logic [dws_pkg::RNG_W-1:0]         pos_next;
	logic [dws_pkg::COST_W+1:0]        side_sum;
	logic [dws_pkg::COST_W+1:0]        twice_best;
	logic [dws_pkg::DEN_W-1:0]         den;
	logic [dws_pkg::QW-1:0]            quo;
	logic                              div_done;
	logic signed [dws_pkg::ACC_W-1:0]  base;
	logic signed [dws_pkg::ACC_W-1:0]  off;
	logic signed [dws_pkg::ACC_W-1:0]  acc;
	logic [dws_pkg::OUT_W-1:0]         sat;

	// Active range, clamped to 1..MAX_RANGE
	always_comb begin
		span = dws_pkg::DIFF_W'($signed(max_disp_q)) - dws_pkg::DIFF_W'($signed(min_disp_q));
		if (span < dws_pkg::RANGE_BOT) begin
			range = dws_pkg::RNG_W'(1);
		end else if (span > dws_pkg::RANGE_TOP) begin
			range = dws_pkg::RNG_W'(dws_pkg::MAX_RANGE);
		end else begin
			range = span[dws_pkg::RNG_W-1:0];
		end
		pos_next = dws_pkg::RNG_W'(position_q) + dws_pkg::RNG_W'(1);
	end

	// Parabola denominator, held at one or more
	always_comb begin
		side_sum   = {2'b00, below_q} + {2'b00, above_q};
		twice_best = {1'b0, best_q, 1'b0};
		if (side_sum <= twice_best) begin
			den = dws_pkg::DEN_W'(1);
		end else begin
			den = dws_pkg::DEN_W'(side_sum - twice_best);
		end
	end

	always_comb begin
		stat.last_cost = pos_next >= range;
		stat.est_ok    = !edge_q &&
		                 !(uniq_q && (dws_pkg::LIM_W'(gap_q) <=
		                   prod_q[dws_pkg::PROD_W-1:dws_pkg::MARGIN_FRAC]));
		stat.div_done  = div_done;
	end

	dws_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({diff_q, {dws_pkg::FRAC_BITS{1'b0}}}),
		.divisor  ({den_q, 1'b0}),
		.quotient (quo),
		.done     (div_done)
	);

	// Final disparity: integer part plus signed offset, saturated
	always_comb begin
		base = dws_pkg::ACC_W'(sum_q) <<< dws_pkg::FRAC_BITS;
		off  = neg_q ? -dws_pkg::ACC_W'(quo) : dws_pkg::ACC_W'(quo);
		acc  = base + off;
		if (acc < dws_pkg::SAT_LO) begin
			sat = dws_pkg::SAT_LO[dws_pkg::OUT_W-1:0];
		end else if (acc > dws_pkg::SAT_HI) begin
			sat = dws_pkg::SAT_HI[dws_pkg::OUT_W-1:0];
		end else begin
			sat = acc[dws_pkg::OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_disp_q <= dws_pkg::MIN_DISP_RST;
			max_disp_q <= dws_pkg::MAX_DISP_RST;
			uniq_q     <= dws_pkg::UNIQ_RST;
			margin_q   <= dws_pkg::MARGIN_RST;
		end else if (cfg_valid) begin
			unique case (dws_pkg::cfg_idx_t'(cfg_index))
				dws_pkg::CFG_DISP_LO:           min_disp_q <= cfg_data[dws_pkg::MIN_W-1:0];
				dws_pkg::CFG_DISP_HI:           max_disp_q <= cfg_data[dws_pkg::MAX_W-1:0];
				dws_pkg::CFG_CHECK_UNIQUE:      uniq_q     <= cfg_data[0];
				dws_pkg::CFG_UNIQUENESS_MARGIN: margin_q   <= cfg_data[dws_pkg::MARGIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
			best_q     <= '1;
			runner_q   <= '1;
			best_pos_q <= '0;
			prev_q     <= '0;
			below_q    <= '0;
			above_q    <= '0;
			await_q    <= 1'b0;
		end else if (cmd.prod_en) begin
			position_q <= '0;
			best_q     <= '1;
			runner_q   <= '1;
			best_pos_q <= '0;
			prev_q     <= '0;
			below_q    <= '0;
			above_q    <= '0;
			await_q    <= 1'b0;
		end else if (cmd.take) begin
			if (position_q == '0) begin
				best_q     <= cost;
				best_pos_q <= '0;
				runner_q   <= '1;
				await_q    <= 1'b1;
			end else if (cost < best_q) begin
				runner_q   <= best_q;
				best_q     <= cost;
				best_pos_q <= position_q;
				below_q    <= prev_q;
				await_q    <= 1'b1;
			end else begin
				if (cost < runner_q) begin
					runner_q <= cost;
				end
				if (await_q) begin
					above_q <= cost;
					await_q <= 1'b0;
				end
			end
			prev_q <= cost;
			if (!stat.last_cost) begin
				position_q <= pos_next[dws_pkg::POS_W-1:0];
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.prod_en) begin
			prod_q <= dws_pkg::PROD_W'(best_q) * dws_pkg::PROD_W'(margin_q);
			gap_q  <= runner_q - best_q;
			edge_q <= (best_pos_q == '0) ||
			          (dws_pkg::RNG_W'(best_pos_q) >= range - dws_pkg::RNG_W'(1));
			sum_q  <= dws_pkg::SUM_W'($signed(min_disp_q)) +
			          $signed(dws_pkg::SUM_W'(best_pos_q));
			diff_q <= (below_q >= above_q) ? below_q - above_q : above_q - below_q;
			neg_q  <= below_q < above_q;
			den_q  <= den;
		end
		if (cmd.check_en) begin
			verdict_q <= stat.est_ok;
		end
		if (cmd.load_out) begin
			disp_q <= verdict_q ? sat : '0;
			vres_q <= verdict_q;
		end
	end

	assign disparity = disp_q;
	assign valid_res = vres_q;

endmodule

// ===== sv/dws_ctrl.sv =====
// Controller: sequences accumulation, end-of-pixel evaluation, division and
// result hand-off. Depends on dws_pkg.

module dws_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  dws_pkg::dws_stat_t stat,
	output dws_pkg::dws_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_ACCUM,
		ST_PROD,
		ST_CHECK,
		ST_DIV,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_full_q;

	always_comb begin
		s_tready     = state_q == ST_ACCUM;
		cmd.take     = s_tvalid && s_tready;
		cmd.prod_en  = state_q == ST_PROD;
		cmd.check_en = state_q == ST_CHECK;
		cmd.div_start = (state_q == ST_CHECK) && stat.est_ok;
		cmd.load_out = (state_q == ST_EMIT) && (!out_full_q || m_tready);
	end

	assign m_tvalid = out_full_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_ACCUM;
			out_full_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_ACCUM: begin
					if (cmd.take && stat.last_cost) begin
						state_q <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_CHECK;
				ST_CHECK: begin
					state_q <= stat.est_ok ? ST_DIV : ST_EMIT;
				end
				ST_DIV: begin
					if (stat.div_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (cmd.load_out) begin
						state_q <= ST_ACCUM;
					end
				end
				default: state_q <= ST_ACCUM;
			endcase
			if (cmd.load_out) begin
				out_full_q <= 1'b1;
			end else if (m_tready) begin
				out_full_q <= 1'b0;
			end
		end
	end

endmodule

// ===== sv/dws_checker.sv =====
// Port-level checks for disparity_winner_select_core, bound to the top level.
// Depends on dws_pkg.

module dws_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [dws_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	// Hold a stalled result word
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result word dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	// Rejected pixels report zero disparity
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata == '0)
		else $error("rejected result carries nonzero disparity");

	// Cost intake closes only on an accepted word
	a_close_on_word: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_tready) |-> $past(s_tvalid))
		else $error("cost intake closed without an accepted word");

endmodule

bind disparity_winner_select_core dws_checker u_dws_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
